// ===== src/priority_ready_queue_core_assert.svh =====
// Assertion macros for the priority ready queue core.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PRIORITY_READY_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
// check under clock, off while reset is high
`define PRQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("prq assertion failed");
// check under clock, also active during reset
`define PRQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("prq assertion failed");
`else
`define PRQ_ASSERT(label, clk, rst, prop)
`define PRQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/prq_pkg.sv =====
// Shared constants for the priority ready queue core: operation codes
// and default sizes. No dependencies.
`default_nettype none

package prq_pkg;

  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_ADD_AUTO = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_TAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROTATE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd5;

  localparam int DEF_PRIO_LEVELS = 32;
  localparam int DEF_MAX_TASKS   = 16;

endpackage

`default_nettype wire

// ===== src/priority_ready_queue_core.sv =====
// Ready queue core: one linked FIFO of task ids per priority level with a
// bitmap of busy levels. Uses prq_pkg and prq_prio_enc.
//
// One operation word is taken per clock while s_axis_tready is high. A word
// is registered on accept, its list and bitmap update commits as it moves
// to the read stage, and the result word (best level, its head task, and
// head/occupancy of the named level as seen after the operation) lands in
// the output register when the word leaves the read stage.
// Throughput is one word per cycle; s_axis_tready drops only while all
// three stages hold words and m_axis_tready is low. The pointer update and
// the lowest-level encoder on the updated bitmap form the single commit
// stage.
`default_nettype none

module priority_ready_queue_core
  import prq_pkg::*;
#(
  parameter int PRIO_LEVELS = DEF_PRIO_LEVELS,
  parameter int MAX_TASKS   = DEF_MAX_TASKS,
  localparam int TW     = $clog2(MAX_TASKS),
  localparam int PW     = $clog2(PRIO_LEVELS),
  localparam int BW     = $clog2(PRIO_LEVELS + 1),
  localparam int IN_W   = TW + 2 * PW,
  localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = BW + 2 * TW + 2,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // task_id, level, current_prio (from bit 0 up)
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  // kind
  input  wire logic [KIND_W-1:0] s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // best_level, best_task, level_head, level_present, level_single
  output logic [OUT_DW-1:0]      m_axis_tdata
);

  localparam logic [BW-1:0] BEST_NONE = BW'(PRIO_LEVELS);

  // input register
  logic              v1;
  logic [KIND_W-1:0] kind1;
  logic [TW-1:0]     t1;
  logic [PW-1:0]     p1;
  logic [PW-1:0]     cur1;

  // read stage
  logic          v2;
  logic [PW-1:0] p2;
  logic          p2_ok;

  // output register
  logic          vo;
  logic [BW-1:0] best_level;
  logic [TW-1:0] best_task;
  logic [TW-1:0] level_head;
  logic          level_present;
  logic          level_single;

  // queue state
  logic [PRIO_LEVELS-1:0] bitmap;
  logic [PRIO_LEVELS-1:0] bitmap_next;
  logic [BW-1:0]          best;
  logic [BW-1:0]          best_next;
  logic [TW-1:0]          level_first [PRIO_LEVELS];
  logic [TW-1:0]          level_last  [PRIO_LEVELS];
  logic [TW-1:0]          link_fwd    [MAX_TASKS];
  logic [TW-1:0]          link_bwd    [MAX_TASKS];

  logic fire1;
  logic mv2;

  assign mv2           = v2 && (!vo || m_axis_tready);
  assign fire1         = v1 && (!v2 || mv2);
  assign s_axis_tready = !v1 || fire1;

  // update logic
  logic          p_ok;
  logic          t_ok;
  logic          on;
  logic          at_tail;
  logic [TW-1:0] f;
  logic [TW-1:0] l;
  logic [TW-1:0] fwd_t;
  logic [TW-1:0] bwd_t;
  logic [TW-1:0] fwd_h;
  logic          first_we;
  logic [TW-1:0] first_wd;
  logic          last_we;
  logic [TW-1:0] last_wd;
  logic          fwd_we;
  logic [TW-1:0] fwd_wa;
  logic [TW-1:0] fwd_wd;
  logic          bwd_we;
  logic [TW-1:0] bwd_wa;
  logic [TW-1:0] bwd_wd;

  always_comb begin
    p_ok    = {1'b0, p1} < (PW + 1)'(PRIO_LEVELS);
    t_ok    = {1'b0, t1} < (TW + 1)'(MAX_TASKS);
    on      = p_ok ? bitmap[p1] : 1'b0;
    f       = level_first[p1];
    l       = level_last[p1];
    fwd_t   = link_fwd[t1];
    bwd_t   = link_bwd[t1];
    fwd_h   = link_fwd[f];
    at_tail = (kind1 == KIND_ADD_TAIL) || ((kind1 == KIND_ADD_AUTO) && (p1 == cur1));

    bitmap_next = bitmap;
    first_we = 1'b0;
    first_wd = t1;
    last_we  = 1'b0;
    last_wd  = t1;
    fwd_we   = 1'b0;
    fwd_wa   = t1;
    fwd_wd   = t1;
    bwd_we   = 1'b0;
    bwd_wa   = t1;
    bwd_wd   = t1;

    if (p_ok) begin
      unique case (kind1)
        KIND_ADD_AUTO, KIND_ADD_HEAD, KIND_ADD_TAIL: begin
          if (t_ok) begin
            if (!on) begin
              first_we        = 1'b1;
              last_we         = 1'b1;
              bitmap_next[p1] = 1'b1;
            end else if (at_tail) begin
              fwd_we  = 1'b1;
              fwd_wa  = l;
              bwd_we  = 1'b1;
              bwd_wd  = l;
              last_we = 1'b1;
            end else begin
              bwd_we   = 1'b1;
              bwd_wa   = f;
              fwd_we   = 1'b1;
              fwd_wd   = f;
              first_we = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          if (t_ok && on) begin
            if (f == t1 && l == t1) begin
              bitmap_next[p1] = 1'b0;
            end else if (f == t1) begin
              first_we = 1'b1;
              first_wd = fwd_t;
            end else if (l == t1) begin
              last_we = 1'b1;
              last_wd = bwd_t;
            end else begin
              // unlink from the middle
              fwd_we = 1'b1;
              fwd_wa = bwd_t;
              fwd_wd = fwd_t;
              bwd_we = 1'b1;
              bwd_wa = fwd_t;
              bwd_wd = bwd_t;
            end
          end
        end
        KIND_ROTATE: begin
          if (on && f != l) begin
            first_we = 1'b1;
            first_wd = fwd_h;
            fwd_we   = 1'b1;
            fwd_wa   = l;
            fwd_wd   = f;
            bwd_we   = 1'b1;
            bwd_wa   = f;
            bwd_wd   = l;
            last_we  = 1'b1;
            last_wd  = f;
          end
        end
        default: begin
        end
      endcase
    end
  end

  prq_prio_enc #(
    .N (PRIO_LEVELS)
  ) u_enc (
    .bits   (bitmap_next),
    .lowest (best_next)
  );

  // read stage sees the state committed by its own word
  logic          on2;
  logic [TW-1:0] head2;
  logic [TW-1:0] best_head;

  always_comb begin
    on2       = p2_ok ? bitmap[p2] : 1'b0;
    head2     = level_first[p2];
    best_head = (best < BEST_NONE) ? level_first[best[PW-1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      vo     <= 1'b0;
      bitmap <= '0;
      best   <= BEST_NONE;
    end else begin
      if (s_axis_tready) begin
        v1 <= s_axis_tvalid;
      end
      if (!v2 || mv2) begin
        v2 <= fire1;
      end
      if (!vo || m_axis_tready) begin
        vo <= mv2;
      end
      if (fire1) begin
        bitmap <= bitmap_next;
        best   <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind1 <= s_axis_tuser;
      t1    <= s_axis_tdata[TW-1:0];
      p1    <= s_axis_tdata[TW+PW-1:TW];
      cur1  <= s_axis_tdata[TW+2*PW-1:TW+PW];
    end
    if (fire1) begin
      p2    <= p1;
      p2_ok <= p_ok;
    end
    if (mv2) begin
      best_level    <= best;
      best_task     <= best_head;
      level_head    <= on2 ? head2 : '0;
      level_present <= on2;
      level_single  <= on2 && (head2 == level_last[p2]);
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && first_we) begin
      level_first[p1] <= first_wd;
    end
    if (fire1 && last_we) begin
      level_last[p1] <= last_wd;
    end
    if (fire1 && fwd_we) begin
      link_fwd[fwd_wa] <= fwd_wd;
    end
    if (fire1 && bwd_we) begin
      link_bwd[bwd_wa] <= bwd_wd;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = OUT_DW'({level_single, level_present, level_head,
                                  best_task, best_level});

  `include "priority_ready_queue_core_assert.svh"

  `PRQ_ASSERT(a_best_none, clk, rst, (bitmap == '0) == (best == BEST_NONE))
  `PRQ_ASSERT(a_best_busy, clk, rst, (best < BEST_NONE) |-> bitmap[best[PW-1:0]])
  `PRQ_ASSERT(a_no_commit_stalled, clk, rst, (v2 && !mv2) |-> !fire1)
  `PRQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (bitmap == '0 && !v2 && !vo))

endmodule

`default_nettype wire

// ===== src/prq_prio_enc.sv =====
// Lowest-set-bit priority encoder over the level bitmap.
// Returns N when no bit is set. No dependencies.
`default_nettype none

module prq_prio_enc #(
  parameter int N = 32
) (
  input  wire logic [N-1:0]           bits,
  output logic      [$clog2(N+1)-1:0] lowest
);

  localparam int IW = $clog2(N);
  localparam int OW = $clog2(N + 1);

  logic [N-1:0]  isolated;
  logic [IW-1:0] idx;

  // isolate lowest one, then OR together the indexes of the set bit
  always_comb begin
    isolated = bits & (~bits + N'(1));
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (isolated[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign lowest = (bits == '0) ? OW'(N) : OW'(idx);

endmodule

`default_nettype wire
